### sv/prsi_pkg.sv
`timescale 1ns / 1ps

package prsi_pkg;

    // Request codes
    localparam logic [7:0] OP_ON    = 8'hAA;
    localparam logic [7:0] OP_OFF   = 8'h55;

    // Rail selects
    localparam logic [7:0] RAIL_PRE = 8'h01;
    localparam logic [7:0] RAIL_SW4 = 8'h02;
    localparam logic [7:0] RAIL_SW5 = 8'h03;
    localparam logic [7:0] RAIL_SW6 = 8'h04;
    localparam logic [7:0] RAIL_SW1 = 8'h05;
    localparam logic [7:0] RAIL_SW2 = 8'h06;
    localparam logic [7:0] RAIL_SW3 = 8'h07;
    localparam logic [7:0] RAIL_ALL = 8'hFF;

    // Enable bit positions
    localparam logic [6:0] EN_PRE   = 7'h01;
    localparam logic [6:0] EN_SW4   = 7'h02;
    localparam logic [6:0] EN_SW5   = 7'h04;
    localparam logic [6:0] EN_SW6   = 7'h08;
    localparam logic [6:0] EN_SW1   = 7'h10;
    localparam logic [6:0] EN_SW2   = 7'h20;
    localparam logic [6:0] EN_SW3   = 7'h40;
    localparam logic [6:0] LOW_FOUR = 7'h0F;

    // Status codes
    localparam logic [2:0] ST_DONE    = 3'd0;
    localparam logic [2:0] ST_REFUSED = 3'd1;
    localparam logic [2:0] ST_PREREQ  = 3'd2;
    localparam logic [2:0] ST_BADRAIL = 3'd3;
    localparam logic [2:0] ST_BADOP   = 3'd4;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] rails;
    } t_result;

    // One request against the current rail set
    function automatic t_result step(input logic [7:0] op, input logic [7:0] rail,
                                     input logic [6:0] s);
        t_result    res;
        logic [6:0] bit_sel;
        begin
            res.status = ST_BADOP;
            res.rails  = s;
            bit_sel    = '0;
            case (rail)
                RAIL_PRE: bit_sel = EN_PRE;
                RAIL_SW4: bit_sel = EN_SW4;
                RAIL_SW5: bit_sel = EN_SW5;
                RAIL_SW6: bit_sel = EN_SW6;
                RAIL_SW1: bit_sel = EN_SW1;
                RAIL_SW2: bit_sel = EN_SW2;
                RAIL_SW3: bit_sel = EN_SW3;
                default:  bit_sel = '0;
            endcase
            if (op == OP_ON) begin
                case (rail)
                    RAIL_PRE: begin
                        if (s == 7'h00) begin
                            res.status = ST_DONE;
                            res.rails  = EN_PRE;
                        end else begin
                            res.status = ST_REFUSED;
                        end
                    end
                    RAIL_SW4: begin
                        if (s == EN_PRE) begin
                            res.status = ST_DONE;
                            res.rails  = s | EN_SW4;
                        end else begin
                            res.status = (s == 7'h00) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW5: begin
                        if (s == 7'h03 || s == 7'h0B) begin
                            res.status = ST_DONE;
                            res.rails  = s | EN_SW5;
                        end else begin
                            res.status = (s < 7'h03) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW6: begin
                        if (s == 7'h03 || s == 7'h07) begin
                            res.status = ST_DONE;
                            res.rails  = s | EN_SW6;
                        end else begin
                            res.status = (s < 7'h03) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW1, RAIL_SW2, RAIL_SW3: begin
                        if ((s & LOW_FOUR) == LOW_FOUR && (s & bit_sel) == 7'h00) begin
                            res.status = ST_DONE;
                            res.rails  = s | bit_sel;
                        end else begin
                            res.status = (s < LOW_FOUR) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    default: res.status = ST_BADRAIL;
                endcase
            end else if (op == OP_OFF) begin
                case (rail)
                    RAIL_PRE: begin
                        if (s == EN_PRE) begin
                            res.status = ST_DONE;
                            res.rails  = 7'h00;
                        end else begin
                            res.status = (s > 7'h01) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW4: begin
                        if (s == 7'h03) begin
                            res.status = ST_DONE;
                            res.rails  = EN_PRE;
                        end else begin
                            res.status = (s > 7'h03) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW5, RAIL_SW6: begin
                        if ((s & bit_sel) != 7'h00 && s < EN_SW1) begin
                            res.status = ST_DONE;
                            res.rails  = s & ~bit_sel;
                        end else begin
                            res.status = (s > EN_SW1) ? ST_PREREQ : ST_REFUSED;
                        end
                    end
                    RAIL_SW1, RAIL_SW2, RAIL_SW3: begin
                        if ((s & bit_sel) != 7'h00) begin
                            res.status = ST_DONE;
                            res.rails  = s & ~bit_sel;
                        end else begin
                            res.status = ST_REFUSED;
                        end
                    end
                    RAIL_ALL: res.status = (s == 7'h00) ? ST_DONE : ST_REFUSED;
                    default:  res.status = ST_BADRAIL;
                endcase
            end
            step = res;
        end
    endfunction

endpackage

### sv/power_rail_sequence_interlock.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Word
// request   in         i_in_valid / o_in_stall    i_op, i_rail
// result    out        o_out_valid / i_out_stall  o_status, o_rail_enables
//
// One request per cycle while o_in_stall is low; its result is registered.
// The rail set updates at the accepting edge, so the next request sees it.
// A two-word result buffer decouples the sides: o_in_stall rises only when
// both words are waiting. Reset (synchronous, low) clears rails and buffer.

module power_rail_sequence_interlock import prsi_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_op,
    input  logic [7:0] i_rail,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_status,
    output logic [6:0] o_rail_enables
);

    logic [6:0] r_rails;
    logic [1:0] r_count;
    t_result    r_buf0;
    t_result    r_buf1;
    t_result    n_res;
    logic       push;
    logic       pop;

    assign o_in_stall  = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign push        = i_in_valid && !o_in_stall;
    assign pop         = o_out_valid && !i_out_stall;
    assign n_res       = step(i_op, i_rail, r_rails);

    // Rail set and buffer occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rails <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_rails <= n_res.rails;
            end
            r_count <= r_count + {1'b0, push} - {1'b0, pop};
        end
    end

    // Result words, head in r_buf0
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_buf0 <= (r_count == 2'd2) ? r_buf1 : n_res;
            if (push) begin
                r_buf1 <= n_res;
            end
        end else if (push) begin
            if (r_count == 2'd0) begin
                r_buf0 <= n_res;
            end else begin
                r_buf1 <= n_res;
            end
        end
    end

    assign o_status       = r_buf0.status;
    assign o_rail_enables = r_buf0.rails;

endmodule

### sv/prsi_checker.sv
`timescale 1ns / 1ps

module prsi_checker import prsi_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_status,
    input logic [6:0] o_rail_enables
);

    // An accepted request always yields a result word next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request gave no result");

    // Input only stalls while results are waiting
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // A stalled result word stays put
    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_rail_enables)))
        else $error("stalled result word changed");

    // Sequencing order holds on shown enables
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (!o_rail_enables[1] || o_rail_enables[0]) &&
            (!(o_rail_enables[2] || o_rail_enables[3]) || (o_rail_enables[1:0] == 2'b11)) &&
            (!(o_rail_enables[6:4] != 3'b000) || (o_rail_enables[3:0] == 4'hF)))
        else $error("rail order violated");

    // Status never exceeds the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_BADOP))
        else $error("status out of range");

endmodule

bind power_rail_sequence_interlock prsi_checker u_prsi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_status       (o_status),
    .o_rail_enables (o_rail_enables)
);

### verif/power_rail_sequence_interlock_test.sv
`timescale 1ns / 1ps

module power_rail_sequence_interlock_test;
    import prsi_pkg::*;

    // Rail sets named by the sequencing order
    localparam logic [6:0] PRE_SW4   = EN_PRE | EN_SW4;
    localparam logic [6:0] ALL_RAILS = 7'h7F;

    // Codes outside the legal sets
    localparam logic [7:0] OP_JUNK   = 8'h00;
    localparam logic [7:0] RAIL_NONE = 8'h00;
    localparam logic [7:0] RAIL_PAST = 8'h08;

    localparam int RANDOM_ITEMS = 1900;
    localparam int DRAIN_LIMIT  = 5000;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] rail;
    } t_request;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] rails;
    } t_interlock_word;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_op;
    logic [7:0] i_rail;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_status;
    logic [6:0] o_rail_enables;

    t_request        request_q[$];
    t_interlock_word expected_q[$];

    logic [6:0] plan_rails;
    logic [6:0] model_rails;
    logic       calm;
    logic       hold_off;
    int         send_gap;
    int         recv_left;
    int         fault_count;
    int         requests_sent;
    int         results_seen;
    int         full_on_seen;
    int         backpressure_cycles;
    int         status_seen[0:7];

    power_rail_sequence_interlock u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_rail         (i_rail),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_rail_enables (o_rail_enables)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Next status and rail set for one request
    function automatic t_interlock_word interlock_predict(input logic [7:0] op,
                                                          input logic [7:0] rail,
                                                          input logic [6:0] s);
        t_interlock_word w;
        logic [6:0]      lane;
        logic [6:0]      partner;
        w.status = ST_BADOP;
        w.rails  = s;
        lane     = '0;
        if (rail >= RAIL_SW1 && rail <= RAIL_SW3) begin
            lane = EN_SW1 << (rail - RAIL_SW1);
        end else if (rail == RAIL_SW5) begin
            lane = EN_SW5;
        end else if (rail == RAIL_SW6) begin
            lane = EN_SW6;
        end
        partner = (rail == RAIL_SW5) ? EN_SW6 : EN_SW5;

        if (op == OP_ON) begin
            case (rail)
                RAIL_PRE: begin
                    if (s == '0) begin
                        w.status = ST_DONE;
                        w.rails  = EN_PRE;
                    end else begin
                        w.status = ST_REFUSED;
                    end
                end
                RAIL_SW4: begin
                    if (s == EN_PRE) begin
                        w.status = ST_DONE;
                        w.rails  = PRE_SW4;
                    end else begin
                        w.status = (s == '0) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                // SW5 and SW6 may come in either order
                RAIL_SW5, RAIL_SW6: begin
                    if (s == PRE_SW4 || s == (PRE_SW4 | partner)) begin
                        w.status = ST_DONE;
                        w.rails  = s | lane;
                    end else begin
                        w.status = (s < PRE_SW4) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                RAIL_SW1, RAIL_SW2, RAIL_SW3: begin
                    if ((s & LOW_FOUR) == LOW_FOUR && (s & lane) == '0) begin
                        w.status = ST_DONE;
                        w.rails  = s | lane;
                    end else begin
                        w.status = (s < LOW_FOUR) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                default: w.status = ST_BADRAIL;
            endcase
        end else if (op == OP_OFF) begin
            case (rail)
                RAIL_PRE: begin
                    if (s == EN_PRE) begin
                        w.status = ST_DONE;
                        w.rails  = '0;
                    end else begin
                        w.status = (s > EN_PRE) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                RAIL_SW4: begin
                    if (s == PRE_SW4) begin
                        w.status = ST_DONE;
                        w.rails  = EN_PRE;
                    end else begin
                        w.status = (s > PRE_SW4) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                // SW5/SW6 only drop once SW1..SW3 are all off
                RAIL_SW5, RAIL_SW6: begin
                    if ((s & lane) != '0 && s < EN_SW1) begin
                        w.status = ST_DONE;
                        w.rails  = s & ~lane;
                    end else begin
                        w.status = (s > EN_SW1) ? ST_PREREQ : ST_REFUSED;
                    end
                end
                RAIL_SW1, RAIL_SW2, RAIL_SW3: begin
                    if ((s & lane) != '0) begin
                        w.status = ST_DONE;
                        w.rails  = s & ~lane;
                    end else begin
                        w.status = ST_REFUSED;
                    end
                end
                // all-off only succeeds when nothing is on
                RAIL_ALL: w.status = (s == '0) ? ST_DONE : ST_REFUSED;
                default:  w.status = ST_BADRAIL;
            endcase
        end
        return w;
    endfunction

    // Idle length: mostly none or short, a few long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (calm) return 0;
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Queue a request and track where the rail set will be after it
    task automatic add_request(input logic [7:0] op, input logic [7:0] rail);
        t_interlock_word w;
        t_request        req;
        req.op   = op;
        req.rail = rail;
        request_q.push_back(req);
        w          = interlock_predict(op, rail, plan_rails);
        plan_rails = w.rails;
    endtask

    // Pick a request that moves the sequence, favoring power-up
    task automatic add_useful_request();
        t_request        ups[$];
        t_request        downs[$];
        t_request        req;
        t_interlock_word w;
        for (int r = RAIL_PRE; r <= RAIL_SW3; r++) begin
            req.rail = r[7:0];
            req.op   = OP_ON;
            w        = interlock_predict(req.op, req.rail, plan_rails);
            if (w.status == ST_DONE) ups.push_back(req);
            req.op   = OP_OFF;
            w        = interlock_predict(req.op, req.rail, plan_rails);
            if (w.status == ST_DONE) downs.push_back(req);
        end
        if (ups.size() != 0 && (downs.size() == 0 || $urandom_range(0, 99) < 62)) begin
            req = ups[$urandom_range(0, ups.size() - 1)];
        end else if (downs.size() != 0) begin
            req = downs[$urandom_range(0, downs.size() - 1)];
        end else begin
            req.op   = OP_OFF;
            req.rail = RAIL_ALL;
        end
        add_request(req.op, req.rail);
    endtask

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("MISMATCH: %s", what);
    endtask

    // Driver: offers queued words, holds them while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_q.push_back(interlock_predict(i_op, i_rail, model_rails));
                model_rails = expected_q[$].rails;
                void'(request_q.pop_front());
                requests_sent++;
                send_gap = pick_idle();
                if ($urandom_range(0, 149) == 0) calm <= ~calm;
            end
            if (i_in_valid && o_in_stall) backpressure_cycles++;
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (request_q.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_op       <= request_q[0].op;
                    i_rail     <= request_q[0].rail;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result word against the oldest expectation
    always @(posedge i_clk) begin
        t_interlock_word want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_left   = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    log_fault($sformatf("unexpected result: status %0d enables %02h",
                                        o_status, o_rail_enables));
                end else begin
                    want = expected_q.pop_front();
                    if (o_status !== want.status || o_rail_enables !== want.rails)
                        log_fault($sformatf(
                            "result %0d: expected status %0d enables %02h, got %0d %02h",
                            results_seen, want.status, want.rails, o_status,
                            o_rail_enables));
                    status_seen[want.status]++;
                    if (want.rails == ALL_RAILS) full_on_seen++;
                end
                results_seen++;
            end
            if (hold_off) begin
                i_out_stall <= 1'b1;
            end else if (recv_left > 0) begin
                recv_left--;
                i_out_stall <= 1'b1;
            end else begin
                recv_left = pick_idle();
                i_out_stall <= 1'b0;
            end
        end
    end

    // Long receiver hold-off so the result buffer fills and stalls the input
    initial begin
        hold_off = 1'b0;
        while (results_seen < 400) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int drain;
        i_rst_n             = 1'b0;
        i_in_valid          = 1'b0;
        i_op                = '0;
        i_rail              = '0;
        i_out_stall         = 1'b0;
        calm                = 1'b0;
        plan_rails          = '0;
        model_rails         = '0;
        fault_count         = 0;
        requests_sent       = 0;
        results_seen        = 0;
        full_on_seen        = 0;
        backpressure_cycles = 0;
        foreach (status_seen[k]) status_seen[k] = 0;

        // Directed: full power-up, refusals, bad codes, full power-down
        add_request(OP_OFF, RAIL_ALL);
        add_request(OP_ON,  RAIL_SW4);
        add_request(OP_OFF, RAIL_PRE);
        add_request(OP_ON,  RAIL_PRE);
        add_request(OP_ON,  RAIL_PRE);
        add_request(OP_ON,  RAIL_SW1);
        add_request(OP_ON,  RAIL_SW4);
        add_request(OP_ON,  RAIL_SW6);
        add_request(OP_ON,  RAIL_SW5);
        add_request(OP_OFF, RAIL_SW4);
        add_request(OP_ON,  RAIL_SW1);
        add_request(OP_ON,  RAIL_SW2);
        add_request(OP_ON,  RAIL_SW3);
        add_request(OP_ON,  RAIL_SW2);
        add_request(OP_OFF, RAIL_SW5);
        add_request(OP_OFF, RAIL_ALL);
        add_request(OP_ON,  RAIL_ALL);
        add_request(OP_OFF, RAIL_NONE);
        add_request(OP_OFF, RAIL_PAST);
        add_request(OP_JUNK, RAIL_PRE);
        add_request(OP_OFF, RAIL_SW3);
        add_request(OP_OFF, RAIL_SW2);
        add_request(OP_OFF, RAIL_SW1);
        add_request(OP_OFF, RAIL_SW6);
        add_request(OP_ON,  RAIL_SW6);
        add_request(OP_OFF, RAIL_SW5);
        add_request(OP_OFF, RAIL_SW6);
        add_request(OP_OFF, RAIL_SW5);
        add_request(OP_OFF, RAIL_SW4);
        add_request(OP_OFF, RAIL_PRE);

        // Random: mostly sequence-advancing words, mixed with legal noise and raw bytes
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            int pick;
            pick = $urandom_range(0, 99);
            if (pick < 58) begin
                add_useful_request();
            end else if (pick < 85) begin
                add_request($urandom_range(0, 1) ? OP_ON : OP_OFF,
                            $urandom_range(0, 7) == 0 ? RAIL_ALL
                                                      : 8'($urandom_range(RAIL_PRE, RAIL_SW3)));
            end else begin
                add_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0) @(posedge i_clk);
        drain = 0;
        while (expected_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_q.size() != 0)
            log_fault($sformatf("%0d results never arrived", expected_q.size()));

        $display("Run covered %0d requests and %0d results; all seven rails on %0d times",
                 requests_sent, results_seen, full_on_seen);
        $display("Status mix done/refused/prereq/bad rail/bad op: %0d/%0d/%0d/%0d/%0d, %0d %s",
                 status_seen[ST_DONE], status_seen[ST_REFUSED], status_seen[ST_PREREQ],
                 status_seen[ST_BADRAIL], status_seen[ST_BADOP], backpressure_cycles,
                 "input stall cycles");
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches in total", fault_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
